[rtl/hchs_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the heading scan.
// Used by hchs_ctrl, hchs_dp and heading_collision_horizon_scan.
`default_nettype none
package hchs_pkg;

  localparam int MAX_HEADINGS = 64;
  localparam int MAX_STEPS    = 256;
  localparam int CORDIC_ITERS = 16;
  localparam int SQRT_ITERS   = 16;
  localparam int DIV_ITERS    = 17;

  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;

  // Register indexes on the APB port
  localparam logic [1:0] REG_STEP    = 2'd0;
  localparam logic [1:0] REG_HORIZON = 2'd1;
  localparam logic [1:0] REG_RADIUS  = 2'd2;
  localparam logic [1:0] REG_HCOUNT  = 2'd3;

  localparam logic [15:0] STEP_RST    = 16'd26;
  localparam logic [15:0] HORIZON_RST = 16'd1280;
  localparam logic [31:0] RADIUS_RST  = 32'd65536;
  localparam logic [6:0]  HCOUNT_RST  = 7'd32;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV,
    ST_HEAD, ST_CORDIC, ST_VX, ST_VY, ST_STEP_INIT, ST_CHECK, ST_MX, ST_MY,
    ST_SX, ST_SY, ST_CMP, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ_X, OP_SQ_Y, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_DIV_INIT, OP_DIV_STEP, OP_HEAD_INIT, OP_CORDIC_STEP, OP_VX, OP_VY,
    OP_STEP_INIT, OP_MX, OP_MY, OP_SX, OP_SY, OP_CMP, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] k;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic t_ok;
    logic hit_now;
    logic out_free;
    logic last_head;
  } status_t;

  function automatic logic [13:0] atan_lut(input logic [3:0] k);
    logic [13:0] v;
    unique case (k)
      4'd0:  v = 14'd8192;
      4'd1:  v = 14'd4836;
      4'd2:  v = 14'd2555;
      4'd3:  v = 14'd1297;
      4'd4:  v = 14'd651;
      4'd5:  v = 14'd326;
      4'd6:  v = 14'd163;
      4'd7:  v = 14'd81;
      4'd8:  v = 14'd41;
      4'd9:  v = 14'd20;
      4'd10: v = 14'd10;
      4'd11: v = 14'd5;
      4'd12: v = 14'd3;
      4'd13: v = 14'd1;
      4'd14: v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/hchs_ctrl.sv]
// Sequencer for the heading scan: walks sqrt, divide, CORDIC and time steps.
// Depends on hchs_pkg; drives hchs_dp through cmd_t, reads status_t.
`default_nettype none
module hchs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hchs_pkg::status_t sts,
  output hchs_pkg::cmd_t       cmd
);

  hchs_pkg::state_t state, state_next;
  logic [4:0] cnt;
  logic [8:0] j;
  logic       cnt_clr;

  assign in_stall = (state != hchs_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      hchs_pkg::ST_IDLE:      if (in_valid) state_next = hchs_pkg::ST_SQX;
      hchs_pkg::ST_SQX:       state_next = hchs_pkg::ST_SQY;
      hchs_pkg::ST_SQY:       state_next = hchs_pkg::ST_SQRT_INIT;
      hchs_pkg::ST_SQRT_INIT: state_next = hchs_pkg::ST_SQRT;
      hchs_pkg::ST_SQRT:
        if (cnt == 5'(hchs_pkg::SQRT_ITERS - 1)) state_next = hchs_pkg::ST_DIV_INIT;
      hchs_pkg::ST_DIV_INIT:  state_next = hchs_pkg::ST_DIV;
      hchs_pkg::ST_DIV:
        if (cnt == 5'(hchs_pkg::DIV_ITERS - 1))
          state_next = sts.n_zero ? hchs_pkg::ST_IDLE : hchs_pkg::ST_HEAD;
      hchs_pkg::ST_HEAD:      state_next = hchs_pkg::ST_CORDIC;
      hchs_pkg::ST_CORDIC:
        if (cnt == 5'(hchs_pkg::CORDIC_ITERS - 1)) state_next = hchs_pkg::ST_VX;
      hchs_pkg::ST_VX:        state_next = hchs_pkg::ST_VY;
      hchs_pkg::ST_VY:        state_next = hchs_pkg::ST_STEP_INIT;
      hchs_pkg::ST_STEP_INIT: state_next = hchs_pkg::ST_CHECK;
      hchs_pkg::ST_CHECK:
        if (j > 9'(hchs_pkg::MAX_STEPS) || !sts.t_ok) state_next = hchs_pkg::ST_EMIT;
        else state_next = hchs_pkg::ST_MX;
      hchs_pkg::ST_MX:        state_next = hchs_pkg::ST_MY;
      hchs_pkg::ST_MY:        state_next = hchs_pkg::ST_SX;
      hchs_pkg::ST_SX:        state_next = hchs_pkg::ST_SY;
      hchs_pkg::ST_SY:        state_next = hchs_pkg::ST_CMP;
      hchs_pkg::ST_CMP:
        state_next = sts.hit_now ? hchs_pkg::ST_EMIT : hchs_pkg::ST_CHECK;
      hchs_pkg::ST_EMIT:
        if (sts.out_free)
          state_next = sts.last_head ? hchs_pkg::ST_IDLE : hchs_pkg::ST_HEAD;
      default:                state_next = hchs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op  = hchs_pkg::OP_NONE;
    cmd.k   = cnt[3:0];
    cnt_clr = 1'b1;
    unique case (state)
      hchs_pkg::ST_IDLE:      if (in_valid) cmd.op = hchs_pkg::OP_LOAD;
      hchs_pkg::ST_SQX:       cmd.op = hchs_pkg::OP_SQ_X;
      hchs_pkg::ST_SQY:       cmd.op = hchs_pkg::OP_SQ_Y;
      hchs_pkg::ST_SQRT_INIT: cmd.op = hchs_pkg::OP_SQRT_INIT;
      hchs_pkg::ST_SQRT: begin
        cmd.op  = hchs_pkg::OP_SQRT_STEP;
        cnt_clr = (cnt == 5'(hchs_pkg::SQRT_ITERS - 1));
      end
      hchs_pkg::ST_DIV_INIT:  cmd.op = hchs_pkg::OP_DIV_INIT;
      hchs_pkg::ST_DIV: begin
        cmd.op  = hchs_pkg::OP_DIV_STEP;
        cnt_clr = (cnt == 5'(hchs_pkg::DIV_ITERS - 1));
      end
      hchs_pkg::ST_HEAD:      cmd.op = hchs_pkg::OP_HEAD_INIT;
      hchs_pkg::ST_CORDIC: begin
        cmd.op  = hchs_pkg::OP_CORDIC_STEP;
        cnt_clr = (cnt == 5'(hchs_pkg::CORDIC_ITERS - 1));
      end
      hchs_pkg::ST_VX:        cmd.op = hchs_pkg::OP_VX;
      hchs_pkg::ST_VY:        cmd.op = hchs_pkg::OP_VY;
      hchs_pkg::ST_STEP_INIT: cmd.op = hchs_pkg::OP_STEP_INIT;
      hchs_pkg::ST_CHECK:     cmd.op = hchs_pkg::OP_NONE;
      hchs_pkg::ST_MX:        cmd.op = hchs_pkg::OP_MX;
      hchs_pkg::ST_MY:        cmd.op = hchs_pkg::OP_MY;
      hchs_pkg::ST_SX:        cmd.op = hchs_pkg::OP_SX;
      hchs_pkg::ST_SY:        cmd.op = hchs_pkg::OP_SY;
      hchs_pkg::ST_CMP:       cmd.op = hchs_pkg::OP_CMP;
      hchs_pkg::ST_EMIT:      if (sts.out_free) cmd.op = hchs_pkg::OP_EMIT;
      default:                cmd.op = hchs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hchs_pkg::ST_IDLE;
      cnt   <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_clr ? 5'd0 : cnt + 5'd1;
      if (state == hchs_pkg::ST_STEP_INIT) j <= 9'd1;
      else if (state == hchs_pkg::ST_CMP) j <= j + 9'd1;
    end
  end

endmodule
`default_nettype wire

[rtl/hchs_dp.sv]
// Datapath: shared multiplier, bitwise sqrt, 65536/n divider, CORDIC,
// distance check and output register. Depends on hchs_pkg.
`default_nettype none
module hchs_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hchs_pkg::cmd_t     cmd,
  output hchs_pkg::status_t       sts,
  input  wire logic [15:0]        step_time,
  input  wire logic [15:0]        horizon_time,
  input  wire logic [31:0]        radius_limit,
  input  wire logic [6:0]         heading_count,
  input  wire logic signed [15:0] rel_x,
  input  wire logic signed [15:0] rel_y,
  input  wire logic signed [15:0] own_vel_x,
  input  wire logic signed [15:0] own_vel_y,
  input  wire logic signed [15:0] obst_vel_x,
  input  wire logic signed [15:0] obst_vel_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              heading_index,
  output logic [15:0]             time_value,
  output logic                    collided,
  output logic                    last
);

  logic signed [15:0] rx, ry, ovx, ovy, bvx, bvy;
  logic [6:0]  n;
  // shared multiplier
  logic signed [26:0] ma;
  logic signed [33:0] mb;
  logic signed [60:0] prod;
  logic [52:0] acc;
  // sqrt
  logic [31:0] rem, root, sbit;
  logic [32:0] rb;
  // divider and phase accumulator
  logic [16:0] ddiv, dq, q_acc;
  logic [6:0]  drem, r_acc;
  logic [7:0]  rem_s, r_sum;
  logic [6:0]  hidx;
  // CORDIC
  logic signed [33:0] cx, cy, xs, ys, cc, cs;
  logic signed [17:0] cz, z0;
  logic signed [15:0] phase;
  logic               flip;
  // stepping
  logic signed [17:0] vr;
  logic signed [18:0] dvx, dvy;
  logic [16:0] t, tv;
  logic        hit;
  logic signed [26:0] dx, dy, dq8;
  logic signed [35:0] dfull;
  logic [53:0] d2;

  assign sts.n_zero    = (n == 7'd0);
  assign sts.t_ok      = (t < {1'b0, horizon_time});
  assign d2            = {1'b0, acc} + {1'b0, prod[52:0]};
  assign sts.hit_now   = (d2 <= {22'd0, radius_limit});
  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.last_head = (hidx + 7'd1 == n);

  assign cc = flip ? -cx : cx;
  assign cs = flip ? -cy : cy;
  assign xs = cx >>> cmd.k;
  assign ys = cy >>> cmd.k;

  assign phase = signed'({~q_acc[15], q_acc[14:0]});
  always_comb begin
    z0 = 18'(phase);
    if (phase > 16'sd16384) z0 = 18'(phase) - 18'sd32768;
    else if (phase < -16'sd16384) z0 = 18'(phase) + 18'sd32768;
  end

  // Q.30 round back to Q9.8 velocity
  logic signed [60:0] prnd;
  assign prnd = prod + 61'sd536870912;
  assign vr   = prnd[47:30];

  // position difference back to Q.8, floor with half added; x in MY, y in SX
  assign dfull = prod[35:0] - ((cmd.op == hchs_pkg::OP_SX) ? (36'(ry) <<< 8) : (36'(rx) <<< 8))
                 + 36'sd128;
  assign dq8   = dfull[34:8];

  assign rb    = {1'b0, root} + {1'b0, sbit};
  assign rem_s = {drem, ddiv[16]};
  assign r_sum = {1'b0, r_acc} + {1'b0, drem};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      hchs_pkg::OP_SQ_X: begin ma = 27'(ovx); mb = 34'(ovx); end
      hchs_pkg::OP_SQ_Y: begin ma = 27'(ovy); mb = 34'(ovy); end
      hchs_pkg::OP_VX:   begin ma = signed'({10'd0, root[16:0]}); mb = cc; end
      hchs_pkg::OP_VY:   begin ma = signed'({10'd0, root[16:0]}); mb = cs; end
      hchs_pkg::OP_MX:   begin ma = 27'(dvx); mb = signed'({17'd0, t}); end
      hchs_pkg::OP_MY:   begin ma = 27'(dvy); mb = signed'({17'd0, t}); end
      hchs_pkg::OP_SX:   begin ma = dx; mb = 34'(dx); end
      hchs_pkg::OP_SY:   begin ma = dy; mb = 34'(dy); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 61'(ma) * 61'(mb);
    case (cmd.op)
      hchs_pkg::OP_LOAD: begin
        rx  <= rel_x;      ry  <= rel_y;
        ovx <= own_vel_x;  ovy <= own_vel_y;
        bvx <= obst_vel_x; bvy <= obst_vel_y;
        n   <= (heading_count > 7'(hchs_pkg::MAX_HEADINGS)) ?
               7'(hchs_pkg::MAX_HEADINGS) : heading_count;
      end
      hchs_pkg::OP_SQ_Y: acc <= prod[52:0];
      hchs_pkg::OP_SQRT_INIT: begin
        rem  <= acc[31:0] + prod[31:0];
        root <= '0;
        sbit <= 32'h4000_0000;
      end
      hchs_pkg::OP_SQRT_STEP: begin
        if ({1'b0, rem} >= rb) begin
          rem  <= rem - rb[31:0];
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      hchs_pkg::OP_DIV_INIT: begin
        ddiv  <= 17'h10000;
        drem  <= '0;
        dq    <= '0;
        q_acc <= '0;
        r_acc <= '0;
        hidx  <= '0;
      end
      hchs_pkg::OP_DIV_STEP: begin
        ddiv <= ddiv << 1;
        if (rem_s >= {1'b0, n}) begin
          drem <= 7'(rem_s - {1'b0, n});
          dq   <= {dq[15:0], 1'b1};
        end else begin
          drem <= rem_s[6:0];
          dq   <= {dq[15:0], 1'b0};
        end
      end
      hchs_pkg::OP_HEAD_INIT: begin
        cx   <= hchs_pkg::INV_GAIN_Q30;
        cy   <= '0;
        cz   <= z0;
        flip <= (phase > 16'sd16384) || (phase < -16'sd16384);
      end
      hchs_pkg::OP_CORDIC_STEP: begin
        if (cz >= 0) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - signed'({4'd0, hchs_pkg::atan_lut(cmd.k)});
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + signed'({4'd0, hchs_pkg::atan_lut(cmd.k)});
        end
      end
      hchs_pkg::OP_VY: dvx <= 19'(vr) - 19'(bvx);
      hchs_pkg::OP_STEP_INIT: begin
        dvy <= 19'(vr) - 19'(bvy);
        t   <= {1'b0, step_time};
        tv  <= '0;
        hit <= 1'b0;
      end
      hchs_pkg::OP_MY: dx <= dq8;
      hchs_pkg::OP_SX: dy <= dq8;
      hchs_pkg::OP_SY: acc <= prod[52:0];
      hchs_pkg::OP_CMP: begin
        tv  <= t;
        hit <= sts.hit_now;
        t   <= t + {1'b0, step_time};
      end
      hchs_pkg::OP_EMIT: begin
        heading_index <= hidx[5:0];
        time_value    <= tv[15:0];
        collided      <= hit;
        last          <= sts.last_head;
        hidx          <= hidx + 7'd1;
        if (r_sum >= {1'b0, n}) begin
          r_acc <= 7'(r_sum - {1'b0, n});
          q_acc <= q_acc + dq + 17'd1;
        end else begin
          r_acc <= r_sum[6:0];
          q_acc <= q_acc + dq;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.op == hchs_pkg::OP_EMIT) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

endmodule
`default_nettype wire

[rtl/heading_collision_horizon_scan.sv]
// Top level: APB register file plus sequencer and datapath of the heading scan.
// Depends on hchs_pkg, hchs_ctrl and hchs_dp.
//
//  channel   signals                                   dir
//  input     in_valid/in_stall, rel_*, own_vel_*, obst_vel_*  in
//  result    out_valid/out_stall, heading_index, time_value, collided, last  out
//  config    psel/penable/pwrite/paddr/pwdata/prdata/pready  APB
//
// One request: a setup phase (squares, 16-step sqrt, 17-step divide and their init
// states), then per heading the CORDIC phase (16-step CORDIC, init, two velocity
// multiplies) plus the time steps on the shared multiplier, one more check when the
// scan ends without a collision, and the emit of the result.
// A stalled result holds the sequencer in its emit state. Reset restores the APB registers to their defaults.
`default_nettype none
module heading_collision_horizon_scan (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] rel_x,
  input  wire logic signed [15:0] rel_y,
  input  wire logic signed [15:0] own_vel_x,
  input  wire logic signed [15:0] own_vel_y,
  input  wire logic signed [15:0] obst_vel_x,
  input  wire logic signed [15:0] obst_vel_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              heading_index,
  output logic [15:0]             time_value,
  output logic                    collided,
  output logic                    last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0] step_time, horizon_time;
  logic [31:0] radius_limit;
  logic [6:0]  heading_count;
  hchs_pkg::cmd_t    cmd;
  hchs_pkg::status_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time     <= hchs_pkg::STEP_RST;
      horizon_time  <= hchs_pkg::HORIZON_RST;
      radius_limit  <= hchs_pkg::RADIUS_RST;
      heading_count <= hchs_pkg::HCOUNT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        hchs_pkg::REG_STEP:    step_time     <= pwdata[15:0];
        hchs_pkg::REG_HORIZON: horizon_time  <= pwdata[15:0];
        hchs_pkg::REG_RADIUS:  radius_limit  <= pwdata;
        hchs_pkg::REG_HCOUNT:  heading_count <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hchs_pkg::REG_STEP:    prdata = {16'd0, step_time};
      hchs_pkg::REG_HORIZON: prdata = {16'd0, horizon_time};
      hchs_pkg::REG_RADIUS:  prdata = radius_limit;
      hchs_pkg::REG_HCOUNT:  prdata = {25'd0, heading_count};
      default:               prdata = '0;
    endcase
  end

  hchs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hchs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .step_time     (step_time),
    .horizon_time  (horizon_time),
    .radius_limit  (radius_limit),
    .heading_count (heading_count),
    .rel_x         (rel_x),
    .rel_y         (rel_y),
    .own_vel_x     (own_vel_x),
    .own_vel_y     (own_vel_y),
    .obst_vel_x    (obst_vel_x),
    .obst_vel_y    (obst_vel_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .heading_index (heading_index),
    .time_value    (time_value),
    .collided      (collided),
    .last          (last)
  );

endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench for heading_collision_horizon_scan: APB register setup, obstacle requests,
// and a scoreboard that predicts the per-heading results. Depends on hchs_pkg and the RTL.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [5:0]  idx;
    logic [15:0] tval;
    logic        hit;
    logic        fin;
  } heading_res_t;

  class heading_scoreboard;
    int unsigned   dt_q88, horizon_q88, radius_q16, n_heads;
    heading_res_t  pending_q[$];
    int            errors;

    function new();
      dt_q88 = hchs_pkg::STEP_RST; horizon_q88 = hchs_pkg::HORIZON_RST;
      radius_q16 = hchs_pkg::RADIUS_RST; n_heads = hchs_pkg::HCOUNT_RST;
      errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // CORDIC rotation in Q1.30, phase in 1/65536 turn
    function void rotate(longint ph, output longint c, output longint s);
      longint x, y, z, xs, ys;
      bit flip;
      x = hchs_pkg::INV_GAIN_Q30; y = 0; z = ph; flip = 0;
      if (z > 16384) begin
        z = z - 32768; flip = 1;
      end else if (z < -16384) begin
        z = z + 32768; flip = 1;
      end
      for (int k = 0; k < hchs_pkg::CORDIC_ITERS; k++) begin
        xs = x >>> k; ys = y >>> k;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(hchs_pkg::atan_lut(k[3:0]));
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(hchs_pkg::atan_lut(k[3:0]));
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_request(logic signed [15:0] px, py, ovx, ovy, bvx, bvy);
      longint rx, ry, spd, c, s, vx, vy, ph, ti, dx, dy, d2;
      longint unsigned t, tv, j, n;
      bit hit;
      heading_res_t r;
      rx = longint'(px) * 256; ry = longint'(py) * 256;
      spd = int_sqrt(longint'(ovx) * ovx + longint'(ovy) * ovy);
      n = (n_heads > hchs_pkg::MAX_HEADINGS) ? hchs_pkg::MAX_HEADINGS : n_heads;
      for (longint unsigned i = 0; i < n; i++) begin
        ph = -32768 + longint'((i * 65536) / n);
        rotate(ph, c, s);
        vx = (spd * c + (longint'(1) << 29)) >>> 30;
        vy = (spd * s + (longint'(1) << 29)) >>> 30;
        j = 1; t = dt_q88; tv = 0; hit = 0;
        while (j <= hchs_pkg::MAX_STEPS && t < horizon_q88) begin
          ti = t;
          dx = (vx * ti - (rx + longint'(bvx) * ti) + 128) >>> 8;
          dy = (vy * ti - (ry + longint'(bvy) * ti) + 128) >>> 8;
          d2 = dx * dx + dy * dy;
          tv = t;
          if (longint'(d2) <= longint'(radius_q16)) begin
            hit = 1;
            break;
          end
          j++;
          t = j * dt_q88;
        end
        r.idx = i[5:0]; r.tval = tv[15:0]; r.hit = hit; r.fin = (i + 1 == n);
        pending_q.push_back(r);
      end
    endfunction

    function void check_result(heading_res_t got);
      heading_res_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: heading_index %0d", got.idx);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.idx !== e.idx) begin
        $error("heading_index: expected %0d, got %0d", e.idx, got.idx); errors++;
      end
      if (got.tval !== e.tval) begin
        $error("time_value: expected %0d, got %0d", e.tval, got.tval); errors++;
      end
      if (got.hit !== e.hit) begin
        $error("collided: expected %0d, got %0d", e.hit, got.hit); errors++;
      end
      if (got.fin !== e.fin) begin
        $error("last: expected %0d, got %0d", e.fin, got.fin); errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 4000000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] rel_x, rel_y, own_vel_x, own_vel_y, obst_vel_x, obst_vel_y;
  logic [5:0]  heading_index;
  logic [15:0] time_value;
  logic        collided, last;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  heading_collision_horizon_scan uut (.*);

  heading_scoreboard sb = new();
  int idle_mode;
  int unsigned cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // receiver side: stall pattern by mode, check at the edge
  always @(negedge clk)
    if (!rst) out_stall <= (idle_mode == 2) ? roll(55) : (idle_mode == 3) ? roll(12) : 1'b0;

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result('{heading_index, time_value, collided, last});

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      hchs_pkg::REG_STEP:    sb.dt_q88 = val[15:0];
      hchs_pkg::REG_HORIZON: sb.horizon_q88 = val[15:0];
      hchs_pkg::REG_RADIUS:  sb.radius_q16 = val;
      default:               sb.n_heads = val[6:0];
    endcase
  endtask

  task automatic configure(int unsigned dt, hz, rad, cnt);
    reg_write(hchs_pkg::REG_STEP, dt);
    reg_write(hchs_pkg::REG_HORIZON, hz);
    reg_write(hchs_pkg::REG_RADIUS, rad);
    reg_write(hchs_pkg::REG_HCOUNT, cnt);
  endtask

  task automatic send_req(logic signed [15:0] px, py, ovx, ovy, bvx, bvy);
    forever begin
      @(negedge clk);
      if ((idle_mode == 1 && roll(55)) || (idle_mode == 3 && roll(12))) begin
        in_valid <= 0;
      end else begin
        break;
      end
    end
    in_valid <= 1;
    rel_x <= px; rel_y <= py; own_vel_x <= ovx; own_vel_y <= ovy;
    obst_vel_x <= bvx; obst_vel_y <= bvy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(px, py, ovx, ovy, bvx, bvy);
  endtask

  // drop valid, wait out all results, then let a request with no result finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_field();
    return roll(50) ? 16'($urandom) : 16'($urandom_range(4095, 0) - 2048);
  endfunction

  task automatic send_random();
    send_req(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field());
  endtask

  initial begin
    int unsigned dt, hz, rad, cnt;
    rst = 1; idle_mode = 0; cycles = 0;
    in_valid = 0; out_stall = 0;
    rel_x = 0; rel_y = 0; own_vel_x = 0; own_vel_y = 0; obst_vel_x = 0; obst_vel_y = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset settings: field extremes, zero speed, head-on approach
    send_req(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_req(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_req(0, 0, 0, 0, 0, 0);
    send_req(16'sd512, 0, 0, 0, 0, 0);
    send_req(16'sd1280, 0, 16'sd512, 0, -16'sd256, 0);
    send_req(-16'sd32768, 16'sh7fff, 0, -16'sd32768, 16'sh7fff, 0);
    drain();

    // zero step: every try at time 0
    idle_mode = 2;
    configure(0, 100, 65536, 4);
    send_req(16'sd100, 16'sd50, 16'sd300, 0, 0, 0);
    send_req(16'sd4000, 16'sd50, 16'sd300, 0, 0, 0);
    drain();

    // step at or beyond horizon: no step possible
    configure(500, 500, 32'hffffffff, 3);
    send_req(0, 0, 16'sd256, 16'sd256, 0, 0);
    drain();
    configure(65535, 1, 0, 1);
    send_req(16'sd10, 0, 0, 0, 0, 0);
    drain();

    // zero heading count yields nothing; oversized count clamps
    idle_mode = 1;
    configure(40, 200, 0, 0);
    send_req(16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6);
    drain();
    configure(40, 200, 32'hffffffff, 127);
    send_req(16'sd300, -16'sd300, 16'sd700, 16'sd100, 0, 0);
    drain();

    // step limit, full heading set, unit step
    idle_mode = 0;
    configure(1, 65535, 0, 64);
    send_req(16'sd20000, 16'sd20000, 16'sd256, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = ph % 4;
      dt = roll(20) ? $urandom_range(65535, 1) : $urandom_range(300, 1);
      hz = dt * $urandom_range(16, 0) + $urandom_range(dt, 0);
      if (hz > 65535) hz = 65535;
      if (hz == 0) hz = 1;
      case ($urandom_range(3, 0))
        0: rad = $urandom;
        1: rad = $urandom_range(32'h00ffffff, 0);
        2: rad = $urandom_range(32'h0003ffff, 0);
        default: rad = roll(50) ? 32'hffffffff : 32'd0;
      endcase
      cnt = roll(15) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      configure(dt, hz, rad, cnt);
      for (int k = 0; k < 7; k++) send_random();
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/hchs_pkg.sv
rtl/hchs_ctrl.sv
rtl/hchs_dp.sv
rtl/heading_collision_horizon_scan.sv
bench/tb.sv
